// File: rtl/core/ott_pkg.sv
// Shared types and constants for the one-shot timer table.
// Request and result codes, cell control and status structs, tick rounding.
// No dependencies.
package ott_pkg;

  localparam int unsigned DEF_SLOTS = 16;

  localparam int unsigned TICK_MS   = 10;
  localparam int unsigned ROUND_UP  = 9;
  localparam int unsigned DIV_SHIFT = 35;
  // reciprocal of the tick length, exact for every sum below 2^25
  localparam logic [31:0] RECIP = 32'(((64'd1 << DIV_SHIFT) / TICK_MS) + 64'd1);

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_CANCEL = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_RUN,
    ST_FINAL
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [1:0]  op;
    logic        adv;
    logic [31:0] now;
    logic [31:0] dl;
    logic [15:0] tag;
    logic [7:0]  hnd;
  } ctl_t;

  // token handed from one cell to the next
  typedef struct packed {
    logic tok;
    logic clm;
  } link_t;

  // per-cell report to the controller
  typedef struct packed {
    logic        tok;
    logic        claim;
    logic        fire;
    logic        cbusy;
    logic [15:0] tag;
  } cell_stat_t;

endpackage

// File: rtl/core/ott_if.sv
// Request and result channel interfaces for the one-shot timer table.
// Valid/ready handshake with payload; no dependencies.
interface ott_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [23:0] wait_ms;
  logic [15:0] tag;
  logic [7:0]  handle;
  logic [31:0] now_ticks;

  modport source (output valid, req_type, wait_ms, tag, handle, now_ticks, input ready);
  modport sink   (input valid, req_type, wait_ms, tag, handle, now_ticks, output ready);
endinterface

interface ott_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        status;
  logic [4:0]  slot_handle;
  logic [15:0] fired_tag;
  logic [4:0]  active_count;
  logic        last;

  modport source (output valid, kind, status, slot_handle, fired_tag, active_count, last,
                  input ready);
  modport sink   (input valid, kind, status, slot_handle, fired_tag, active_count, last,
                  output ready);
endinterface

// File: rtl/core/ott_cell.sv
// One timer slot of the chain: busy bit, deadline and tag.
// Acts on the request while it holds the token, then hands it on. Uses ott_pkg.
module ott_cell
  import ott_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctl_t       ctl,
  input  link_t      lnk_in,
  output link_t      lnk_out,
  output cell_stat_t stat
);

  logic        busy_r;
  logic        tok_r;
  logic        clm_r;
  logic [31:0] dl_r;
  logic [15:0] tag_r;
  logic [31:0] diff;
  logic        claim_c;
  logic        fire_c;
  logic        canc_c;

  assign diff    = ctl.now - dl_r;
  assign claim_c = tok_r && (ctl.op == REQ_ADD) && !clm_r && !busy_r;
  assign fire_c  = tok_r && (ctl.op == REQ_TICK) && busy_r && !diff[31];
  assign canc_c  = tok_r && (ctl.op == REQ_CANCEL) && (ctl.hnd == 8'(IDX + 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      tok_r  <= 1'b0;
      clm_r  <= 1'b0;
    end else if (ctl.adv) begin
      tok_r <= lnk_in.tok;
      clm_r <= lnk_in.clm;
      if (claim_c) begin
        busy_r <= 1'b1;
      end else if (fire_c || canc_c) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv && claim_c) begin
      dl_r  <= ctl.dl;
      tag_r <= ctl.tag;
    end
  end

  assign lnk_out.tok = tok_r;
  assign lnk_out.clm = clm_r || claim_c;

  assign stat.tok   = tok_r;
  assign stat.claim = claim_c;
  assign stat.fire  = fire_c;
  assign stat.cbusy = canc_c && busy_r;
  assign stat.tag   = tag_r;

endmodule

// File: rtl/core/ott_ctrl.sv
// Sequencer for the timer table: takes requests, launches the token down
// the cell chain, keeps the active count and drives the result register. Uses ott_pkg.
module ott_ctrl
  import ott_pkg::*;
#(
  parameter int unsigned SLOTS = DEF_SLOTS
) (
  input  logic             clk,
  input  logic             rst_n,
  ott_in_if.sink           in_req,
  ott_out_if.source        out_res,
  input  cell_stat_t       stat [SLOTS],
  output ctl_t             ctl,
  output logic             launch
);

  localparam int unsigned CW = $clog2(SLOTS + 1);

  state_t      state_r, state_nxt;
  logic [1:0]  op_r;
  logic [24:0] sum_r;
  logic [15:0] tag_r;
  logic [7:0]  hnd_r;
  logic [31:0] now_r;
  logic [56:0] prod_r;
  logic [31:0] dl_r;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        err_r;
  logic        got_r;
  logic [4:0]  hres_r;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  o_kind_r;
  logic        o_status_r;
  logic [4:0]  o_handle_r;
  logic [15:0] o_tag_r;
  logic [4:0]  o_cnt_r;
  logic        o_last_r;

  logic        accept;
  logic        hnd_ok;
  logic        can_load;
  logic        adv;
  logic        any_fire, any_claim, any_cbusy;
  logic [15:0] fire_tag;
  logic [SLOTS-1:0] tok_vec;
  logic        last_exit;
  logic        ld_fire, ld_final;
  logic [31:0] q32;
  logic [31:0] delta;
  logic [7:0]  hsum;
  logic [CW-1:0] cnt_dec;
  logic [CW+4:0] cnt_ext, dec_ext;

  always_comb begin
    any_fire  = 1'b0;
    any_claim = 1'b0;
    any_cbusy = 1'b0;
    fire_tag  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tok_vec[i] = stat[i].tok;
      any_fire   = any_fire  | stat[i].fire;
      any_claim  = any_claim | stat[i].claim;
      any_cbusy  = any_cbusy | stat[i].cbusy;
      fire_tag   = fire_tag  | (stat[i].tag & {16{stat[i].fire}});
    end
  end

  assign accept    = in_req.valid && in_req.ready;
  assign hnd_ok    = (in_req.handle != 8'd0) && (in_req.handle <= 8'(SLOTS));
  assign can_load  = !out_valid_r || out_res.ready;
  assign adv       = !(any_fire && !can_load);
  assign last_exit = stat[SLOTS-1].tok && adv;
  assign q32       = 32'(prod_r >> DIV_SHIFT);
  assign delta     = (q32 == 32'd0) ? 32'd1 : q32;
  assign hsum      = {{(8 - CW){1'b0}}, pos_r} + 8'd1;
  assign cnt_dec   = cnt_r - CW'(1);
  assign cnt_ext   = {5'd0, cnt_r};
  assign dec_ext   = {5'd0, cnt_dec};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req.req_type)
            REQ_ADD:    state_nxt = (in_req.tag == 16'd0) ? ST_FINAL : ST_MUL;
            REQ_CANCEL: state_nxt = hnd_ok ? ST_RUN : ST_FINAL;
            REQ_TICK:   state_nxt = ST_RUN;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MUL:   state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_RUN;
      ST_RUN:   state_nxt = last_exit ? ST_FINAL : ST_RUN;
      ST_FINAL: state_nxt = can_load ? ST_IDLE : ST_FINAL;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_req.ready = 1'b0;
    launch       = 1'b0;
    ld_fire      = 1'b0;
    ld_final     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_req.ready = 1'b1;
        launch = accept && (((in_req.req_type == REQ_CANCEL) && hnd_ok) ||
                            (in_req.req_type == REQ_TICK));
      end
      ST_MUL:   ;
      ST_DIV:   launch = 1'b1;
      ST_RUN:   ld_fire = any_fire && can_load;
      ST_FINAL: ld_final = can_load;
      default:  ;
    endcase
  end

  assign ctl.op  = op_r;
  assign ctl.adv = adv;
  assign ctl.now = now_r;
  assign ctl.dl  = dl_r;
  assign ctl.tag = tag_r;
  assign ctl.hnd = hnd_r;

  always_comb begin
    pos_nxt = pos_r;
    if (launch) begin
      pos_nxt = '0;
    end else if ((state_r == ST_RUN) && adv) begin
      pos_nxt = pos_r + CW'(1);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (adv) begin
      if (any_claim) begin
        cnt_nxt = cnt_r + CW'(1);
      end else if (any_fire || any_cbusy) begin
        cnt_nxt = cnt_dec;
      end
    end
  end

  assign out_valid_nxt = (ld_fire || ld_final) ? 1'b1 :
                         (out_res.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      got_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        got_r <= 1'b0;
      end else if (adv && any_claim) begin
        got_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_req.req_type;
      sum_r <= {1'b0, in_req.wait_ms} + 25'(ROUND_UP);
      tag_r <= in_req.tag;
      hnd_r <= in_req.handle;
      now_r <= in_req.now_ticks;
      err_r <= !hnd_ok;
    end
    if (state_r == ST_MUL) begin
      prod_r <= {32'd0, sum_r} * {25'd0, RECIP};
    end
    if (state_r == ST_DIV) begin
      dl_r <= now_r + delta;
    end
    if (adv && any_claim) begin
      hres_r <= hsum[4:0];
    end
    if (ld_fire) begin
      o_kind_r   <= KIND_FIRED;
      o_status_r <= 1'b0;
      o_handle_r <= hsum[4:0];
      o_tag_r    <= fire_tag;
      o_cnt_r    <= dec_ext[4:0];
      o_last_r   <= 1'b0;
    end else if (ld_final) begin
      o_tag_r  <= '0;
      o_cnt_r  <= cnt_ext[4:0];
      o_last_r <= 1'b1;
      case (op_r)
        REQ_ADD: begin
          o_kind_r   <= KIND_ADD;
          o_status_r <= !got_r;
          o_handle_r <= got_r ? hres_r : 5'd0;
        end
        REQ_CANCEL: begin
          o_kind_r   <= KIND_CANCEL;
          o_status_r <= err_r;
          o_handle_r <= 5'd0;
        end
        default: begin
          o_kind_r   <= KIND_DONE;
          o_status_r <= 1'b0;
          o_handle_r <= 5'd0;
        end
      endcase
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.kind         = o_kind_r;
  assign out_res.status       = o_status_r;
  assign out_res.slot_handle  = o_handle_r;
  assign out_res.fired_tag    = o_tag_r;
  assign out_res.active_count = o_cnt_r;
  assign out_res.last         = o_last_r;

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tok_vec))
    else $error("more than one cell holds the token");
  a_run_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> $onehot(tok_vec))
    else $error("token lost during a scan");
  a_launch_empty: assert property (@(posedge clk) disable iff (!rst_n)
    launch |-> (tok_vec == '0))
    else $error("launch while the chain is busy");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(SLOTS))
    else $error("active count above table size");

endmodule

// File: rtl/core/one_shot_timer_table_top.sv
// Top level of the one-shot timer table: controller plus a chain of slot cells.
// Depends on ott_pkg, ott_if, ott_cell and ott_ctrl.
//
// Usage:
//   in_req carries add, cancel and tick requests (valid/ready). out_res
//   returns one reply per add or cancel, and for a tick one fired request per
//   expired slot, lowest slot first, followed by a done request with last=1.
//   Request type 3 is dropped without a result.
// Flow:
//   A request walks a token down the SLOTS cells, one cell per cycle unless
//   the chain is held (see Stalls). Add first rounds the wait to ticks in the
//   ST_MUL and ST_DIV states before the walk. A null tag or a bad handle is
//   answered from ST_FINAL, without a walk.
//   One request is in flight at a time; in_req is ready again once the final
//   result sits in the output register.
// Stalls: a fired slot waits in its cell while the output register is full,
//   and the whole chain holds until the receiver takes the result.
// Reset: synchronous, active low; clears every busy bit, the active count
//   and the output valid bit.
module one_shot_timer_table_top
  import ott_pkg::*;
#(
  parameter int unsigned SLOTS = DEF_SLOTS
) (
  input  logic       clk,
  input  logic       rst_n,
  ott_in_if.sink     in_req,
  ott_out_if.source  out_res
);

  ctl_t       ctl;
  logic       launch;
  link_t      lnk  [SLOTS+1];
  cell_stat_t stat [SLOTS];

  assign lnk[0].tok = launch;
  assign lnk[0].clm = 1'b0;

  ott_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .stat    (stat),
    .ctl     (ctl),
    .launch  (launch)
  );

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    ott_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .lnk_in  (lnk[g]),
      .lnk_out (lnk[g+1]),
      .stat    (stat[g])
    );
  end

endmodule

// File: sim/one_shot_timer_table_top_test.sv
`timescale 1ns / 100ps
// Self-checking test of one_shot_timer_table_top: add, cancel and tick requests
// against a slot table kept in the test. Uses ott_pkg, ott_if and the RTL top.
module one_shot_timer_table_top_test;
  import ott_pkg::*;

  localparam int unsigned SLOT_COUNT  = DEF_SLOTS;
  localparam int unsigned SLOT_BITS   = $clog2(SLOT_COUNT);
  localparam int unsigned TICK_LEN_MS = 10;
  localparam int unsigned ROUND_MS    = 9;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam int          RANDOM_ITEMS = 500;
  localparam int          TAIL_ITEMS   = 60;
  localparam int          LONG_HOLD    = 400;
  localparam int          CYCLE_LIMIT  = 600_000;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [23:0] wait_ms;
    logic [15:0] tag;
    logic [7:0]  handle;
    logic [31:0] now_ticks;
  } timer_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        status;
    logic [4:0]  slot_handle;
    logic [15:0] fired_tag;
    logic [4:0]  active_count;
    logic        last;
  } timer_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ott_in_if  in_if ();
  ott_out_if out_if ();

  one_shot_timer_table_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_if),
    .out_res(out_if)
  );

  always #1 clk = ~clk;

  // slot table as the block should hold it
  bit          slot_busy [SLOT_COUNT];
  logic [31:0] slot_deadline [SLOT_COUNT];
  logic [15:0] slot_tag [SLOT_COUNT];

  timer_req_t   request_backlog[$];
  timer_reply_t replies_due[$];

  int  mismatch_count;
  int  replies_checked;
  int  scored_items;
  int  cycle_count;
  int  n_adds, n_null_tag, n_full, n_cancels, n_bad_handle, n_ticks, n_fired;
  bit  quiet_tail;
  logic [31:0] gen_now;

  function automatic logic [4:0] busy_slots();
    logic [4:0] cnt;
    cnt = '0;
    for (int i = 0; i < SLOT_COUNT; i++) cnt += 5'(slot_busy[i]);
    return cnt;
  endfunction

  task automatic post_reply(input logic [1:0] kind, input logic status,
                            input logic [4:0] hnd, input logic [15:0] tag,
                            input logic last);
    replies_due.push_back('{kind, status, hnd, tag, busy_slots(), last});
  endtask

  task automatic run_table_request(input timer_req_t r);
    logic [31:0] delta;
    logic [31:0] gap;
    bit          placed;
    case (r.req_type)
      REQ_ADD: begin
        n_adds++;
        if (r.tag == '0) begin
          n_null_tag++;
          post_reply(KIND_ADD, 1'b1, '0, '0, 1'b1);
        end else begin
          delta = (32'(r.wait_ms) + ROUND_MS) / TICK_LEN_MS;
          if (delta == '0) delta = 32'd1;
          placed = 1'b0;
          for (int i = 0; i < SLOT_COUNT && !placed; i++) begin
            if (!slot_busy[i]) begin
              slot_busy[i]     = 1'b1;
              slot_deadline[i] = r.now_ticks + delta;
              slot_tag[i]      = r.tag;
              placed           = 1'b1;
              post_reply(KIND_ADD, 1'b0, 5'(i + 1), '0, 1'b1);
            end
          end
          if (!placed) begin
            n_full++;
            post_reply(KIND_ADD, 1'b1, '0, '0, 1'b1);
          end
        end
      end
      REQ_CANCEL: begin
        n_cancels++;
        if (r.handle == 8'd0 || r.handle > 8'(SLOT_COUNT)) begin
          n_bad_handle++;
          post_reply(KIND_CANCEL, 1'b1, '0, '0, 1'b1);
        end else begin
          slot_busy[SLOT_BITS'(r.handle - 8'd1)] = 1'b0;
          post_reply(KIND_CANCEL, 1'b0, '0, '0, 1'b1);
        end
      end
      REQ_TICK: begin
        n_ticks++;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_busy[i]) begin
            gap = r.now_ticks - slot_deadline[i];
            if (!gap[31]) begin
              slot_busy[i] = 1'b0;
              n_fired++;
              post_reply(KIND_FIRED, 1'b0, 5'(i + 1), slot_tag[i], 1'b0);
            end
          end
        end
        post_reply(KIND_DONE, 1'b0, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic queue_request(input logic [1:0] rt, input int unsigned dly,
                               input int unsigned tag, input int unsigned hnd,
                               input logic [31:0] now);
    request_backlog.push_back('{rt, 24'(dly), 16'(tag), 8'(hnd), now});
    if (rt != REQ_UNUSED) scored_items++;
  endtask

  function automatic int unsigned pick_tag();
    if ($urandom_range(0, 19) == 0) return 0;
    return $urandom_range(1, 'hFFFF);
  endfunction

  function automatic int unsigned pick_handle();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 255);
    return $urandom_range(1, SLOT_COUNT);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // request driver
  bit offer;
  int gap_left;
  timer_req_t next_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      offer = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        run_table_request('{in_if.req_type, in_if.wait_ms, in_if.tag, in_if.handle,
                            in_if.now_ticks});
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_backlog.size() != 0) begin
          if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 10) - 1;
          end else begin
            next_req = request_backlog.pop_front();
            in_if.req_type  <= next_req.req_type;
            in_if.wait_ms   <= next_req.wait_ms;
            in_if.tag       <= next_req.tag;
            in_if.handle    <= next_req.handle;
            in_if.now_ticks <= next_req.now_ticks;
            offer = 1'b1;
          end
        end
      end
      in_if.valid <= offer;
      quiet_tail  <= request_backlog.size() < TAIL_ITEMS;
    end
  end

  // reply monitor
  int hold_left;
  bit long_hold_done;
  timer_reply_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        replies_checked++;
        if (replies_due.size() == 0) begin
          $error("unexpected reply: kind %0d handle %0d tag %0d", out_if.kind,
                 out_if.slot_handle, out_if.fired_tag);
          mismatch_count++;
        end else begin
          want = replies_due.pop_front();
          check_field("kind", 16'(want.kind), 16'(out_if.kind));
          check_field("status", 16'(want.status), 16'(out_if.status));
          check_field("slot_handle", 16'(want.slot_handle), 16'(out_if.slot_handle));
          check_field("fired_tag", want.fired_tag, out_if.fired_tag);
          check_field("active_count", 16'(want.active_count), 16'(out_if.active_count));
          check_field("last", 16'(want.last), 16'(out_if.last));
        end
      end
      // one long hold-off so the table backs up into the request side
      if (!long_hold_done && replies_checked >= 150) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 10) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    in_if.valid     = 1'b0;
    in_if.req_type  = '0;
    in_if.wait_ms   = '0;
    in_if.tag       = '0;
    in_if.handle    = '0;
    in_if.now_ticks = '0;
    out_if.ready    = 1'b0;

    // directed: empty tick, null tag, rounding, wrap, bad handles, ignored type
    queue_request(REQ_TICK,   $urandom, $urandom, $urandom, 32'd0);
    queue_request(REQ_ADD,    5, 0, $urandom, 32'd0);
    queue_request(REQ_ADD,    0, 'hFFFF, $urandom, 32'd0);
    queue_request(REQ_ADD,    'hFF_FFFF, 1, $urandom, 32'hFFFF_FFFF);
    queue_request(REQ_ADD,    1, 'h8000, $urandom, 32'd100);
    queue_request(REQ_ADD,    10, 'h1234, $urandom, 32'd100);
    queue_request(REQ_ADD,    11, 'h5AA5, $urandom, 32'd100);
    queue_request(REQ_CANCEL, $urandom, $urandom, 0, $urandom);
    queue_request(REQ_CANCEL, $urandom, $urandom, SLOT_COUNT + 1, $urandom);
    queue_request(REQ_CANCEL, $urandom, $urandom, 255, $urandom);
    queue_request(REQ_CANCEL, $urandom, $urandom, SLOT_COUNT, $urandom);
    queue_request(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom);
    queue_request(REQ_TICK,   $urandom, $urandom, $urandom, 32'd1);
    queue_request(REQ_CANCEL, $urandom, $urandom, 4, $urandom);
    queue_request(REQ_TICK,   $urandom, $urandom, $urandom, 32'd101);
    queue_request(REQ_TICK,   $urandom, $urandom, $urandom, 32'h8000_0000 + 32'd1677721);
    queue_request(REQ_TICK,   $urandom, $urandom, $urandom, 32'h7FFF_FFFF + 32'd1677721);
    queue_request(REQ_TICK,   $urandom, $urandom, $urandom, 32'd102);

    gen_now = 32'd200;
    while (scored_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          repeat ($urandom_range(1, 6))
            queue_request(REQ_ADD, $urandom_range(0, 120), pick_tag(), $urandom, gen_now);
          if ($urandom_range(0, 2) == 0)
            queue_request(REQ_CANCEL, $urandom, $urandom, pick_handle(), $urandom);
          repeat ($urandom_range(1, 6)) begin
            gen_now += $urandom_range(0, 5);
            queue_request(REQ_TICK, $urandom, $urandom, $urandom, gen_now);
          end
        end
        4: begin
          repeat ($urandom_range(14, 20))
            queue_request(REQ_ADD, $urandom_range(0, 300), pick_tag(), $urandom, gen_now);
        end
        5: begin
          repeat ($urandom_range(1, 4))
            queue_request(REQ_CANCEL, $urandom, $urandom, pick_handle(), $urandom);
        end
        6: begin
          if ($urandom_range(0, 1) == 0) gen_now = $urandom;
          else gen_now = 32'hFFFF_FFF0 + $urandom_range(0, 8);
          queue_request(REQ_TICK, $urandom, $urandom, $urandom, gen_now);
        end
        7: begin
          repeat ($urandom_range(1, 3))
            queue_request(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
        end
        8: begin
          repeat ($urandom_range(1, 3))
            queue_request(REQ_ADD, $urandom_range(0, 'hFF_FFFF), pick_tag(), $urandom,
                          gen_now);
        end
        default: begin
          gen_now += $urandom_range(0, 2000000);
          queue_request(REQ_TICK, $urandom, $urandom, $urandom, gen_now);
        end
      endcase
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (request_backlog.size() != 0 || in_if.valid) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (2 * SLOT_COUNT + 8) @(posedge clk);

    $display("Ran %0d adds (%0d null tag, %0d table full), %0d cancels (%0d bad handle),",
             n_adds, n_null_tag, n_full, n_cancels, n_bad_handle);
    $display("%0d tick scans firing %0d timers; %0d replies checked, %0d mismatches",
             n_ticks, n_fired, replies_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ott_pkg.sv
rtl/core/ott_if.sv
rtl/core/ott_cell.sv
rtl/core/ott_ctrl.sv
rtl/core/one_shot_timer_table_top.sv
sim/one_shot_timer_table_top_test.sv
